[rtl/core/ddo_pkg.sv]
// Shared types, constants and tables for the differential-drive odometry block.
// Depends on nothing; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package ddo_pkg;

   // widths of the item fields
   localparam int CNT_W     = 32;
   localparam int ANG_W     = 48;
   localparam int POS_W     = 48;
   localparam int HEAD_W    = 28;
   localparam int LIM_W     = 31;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_TO_RADIAN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_SCALE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_RADIUS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GLITCH_LIMIT    = 3'd3;

   // register reset values
   localparam logic [31:0]      RST_COUNT_TO_RADIAN = 32'd16777;
   localparam logic [31:0]      RST_ROTATION_SCALE  = 32'd16777216;
   localparam logic [31:0]      RST_WHEEL_RADIUS    = 32'd838861;
   localparam logic [LIM_W-1:0] RST_GLITCH_LIMIT    = 31'd167772160;

   // angles in Q4.24
   localparam logic signed [HEAD_W-1:0] TWO_PI  = 28'sd105414357;
   localparam logic signed [HEAD_W-1:0] PI      = 28'sd52707179;
   localparam logic signed [HEAD_W-1:0] HALF_PI = 28'sd26353589;
   localparam logic [31:0]              TWO_PI_U = 32'd105414357;

   // rotator: Q2.30 in a 34-bit signed word
   localparam int                 ROT_W       = 34;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam int                 CORDIC_STEPS_DEF = 24;

   // saturation bound for angles and distance
   localparam logic [46:0] SAT47 = {47{1'b1}};

   // queue between front and back
   localparam int QDEPTH = 2;

   typedef struct packed {
      logic signed [CNT_W-1:0] left_count;
      logic signed [CNT_W-1:0] right_count;
      logic                    clear_history;
   } ddo_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [HEAD_W-1:0] heading;
      logic                     pose_updated;
   } ddo_rsp_type;

   // count deltas handed from front to back
   typedef struct packed {
      logic signed [CNT_W-1:0] d_left;
      logic signed [CNT_W-1:0] d_right;
   } ddo_delta_type;

   typedef struct packed {
      logic [31:0]      count_to_radian;
      logic [31:0]      rotation_scale;
      logic [31:0]      wheel_radius;
      logic [LIM_W-1:0] glitch_limit;
   } ddo_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_DALF,
      ST_CHECK,
      ST_DIST,
      ST_HSUM,
      ST_WRAP,
      ST_CSTART,
      ST_CWAIT,
      ST_XMUL,
      ST_XADD,
      ST_YMUL,
      ST_YADD,
      ST_OUT
   } ddo_state_type;

   typedef struct packed {
      logic pop;
      logic cordic_start;
      logic rsp_load;
   } ddo_back_ctl_type;

   // atan(2^-k) in Q2.30, truncated up to k = 26 and rounded above
   function automatic logic [29:0] atan_q30(input logic [4:0] k);
      logic [29:0] v;
      unique case (k)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         5'd31: v = 30'd0;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/ddo_front.sv]
// Front end: takes request beats, keeps the last count per wheel, emits count deltas.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_front import ddo_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ddo_req_type   req_payload,
   input  logic          q_full,
   output logic          push,
   output ddo_delta_type push_data
);

   logic [CNT_W-1:0] last_left_ff, last_left_in;
   logic [CNT_W-1:0] last_right_ff, last_right_in;
   logic [CNT_W-1:0] hist_left, hist_right;

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   // a cleared or zero history gives a zero delta
   always_comb begin
      hist_left  = req_payload.clear_history ? '0 : last_left_ff;
      hist_right = req_payload.clear_history ? '0 : last_right_ff;
      push_data.d_left  = (hist_left == '0) ? '0 :
                          $signed(req_payload.left_count - hist_left);
      push_data.d_right = (hist_right == '0) ? '0 :
                          $signed(req_payload.right_count - hist_right);
      last_left_in  = push ? req_payload.left_count  : last_left_ff;
      last_right_in = push ? req_payload.right_count : last_right_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff  <= '0;
         last_right_ff <= '0;
      end else begin
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
      end
   end

endmodule

[rtl/core/ddo_queue.sv]
// Short FIFO of count deltas between front and back.
// Depends on ddo_pkg.
`timescale 1ns / 1ps

module ddo_queue import ddo_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ddo_delta_type push_data,
   output logic          full,
   input  logic          pop,
   output ddo_delta_type pop_data,
   output logic          not_empty
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   ddo_delta_type     entry_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign full      = (count_ff == CW'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/ddo_cordic.sv]
// Iterative rotation-mode CORDIC: cos and sin of a Q4.24 heading in Q2.30.
// Depends on ddo_pkg (gain, angle constants, atan table).
`timescale 1ns / 1ps

module ddo_cordic import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [HEAD_W-1:0] heading,
   output logic                     done,
   output logic signed [ROT_W-1:0]  cos_out,
   output logic signed [ROT_W-1:0]  sin_out
);

   localparam int ITW = $clog2(CORDIC_STEPS);

   logic signed [ROT_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ITW-1:0]          iter_ff, iter_in;
   logic                    run_ff, run_in, done_ff, done_in, flip_ff, flip_in;
   logic signed [29:0]      h_wide, h_half;
   logic                    fold;
   logic [4:0]              k;
   logic signed [ROT_W-1:0] sx, sy, ang;

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

   // range fold to [-pi/2, pi/2]
   always_comb begin
      h_wide = 30'(heading);
      if (h_wide > 30'(PI)) begin
         h_wide = h_wide - 30'(TWO_PI);
      end else if (h_wide < -30'(PI)) begin
         h_wide = h_wide + 30'(TWO_PI);
      end
      fold   = 1'b0;
      h_half = h_wide;
      if (h_wide > 30'(HALF_PI)) begin
         h_half = h_wide - 30'(PI);
         fold   = 1'b1;
      end else if (h_wide < -30'(HALF_PI)) begin
         h_half = h_wide + 30'(PI);
         fold   = 1'b1;
      end
   end

   // one micro-rotation per cycle
   always_comb begin
      k       = 5'(iter_ff);
      sx      = x_ff >>> k;
      sy      = y_ff >>> k;
      ang     = $signed({4'b0, atan_q30(k)});
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      run_in  = run_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = $signed({h_half[27:0], 6'b0});
         iter_in = '0;
         run_in  = 1'b1;
         flip_in = fold;
      end else if (run_ff) begin
         if (!z_ff[ROT_W-1]) begin
            x_in = x_ff - sy;
            y_in = y_ff + sx;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + sy;
            y_in = y_ff - sx;
            z_in = z_ff + ang;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITW'(CORDIC_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
         flip_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
         flip_ff <= flip_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule

[rtl/core/ddo_back.sv]
// Back end: sequencer that turns count deltas into heading and position updates.
// Depends on ddo_pkg and ddo_cordic; one shared 32x32 multiplier, 24-bit split for wide operands.
`timescale 1ns / 1ps

module ddo_back import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ddo_cfg_type   cfg,
   input  logic          q_valid,
   input  ddo_delta_type q_data,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ddo_rsp_type   rsp_payload
);

   ddo_state_type    state_ff, state_in;
   ddo_back_ctl_type ctl;

   logic [1:0]              ph_ff, ph_in;
   logic signed [CNT_W-1:0] d0_ff, d1_ff;
   logic signed [ANG_W-1:0] a0_ff, a1_ff;
   logic [47:0]             mag_ff;
   logic [31:0]             m_ff;
   logic                    neg_ff;
   logic [63:0]             prod_ff;
   logic [79:0]             acc_ff;
   logic                    ok_ff;
   logic                    dalf_neg_ff;
   logic [LIM_W-1:0]        dalf_mag_ff;
   logic                    dist_neg_ff;
   logic [46:0]             dist_mag_ff;
   logic                    h_neg_ff;
   logic [31:0]             h_mag_ff;
   logic [2:0]              wstep_ff;
   logic signed [HEAD_W-1:0] heading_ff;
   logic [POS_W-1:0]        x_ff, y_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   ddo_rsp_type             rsp_ff;

   logic [31:0]             mul_a, mul_b;
   logic [63:0]             prod_in;
   logic [31:0]             d_mag;
   logic [46:0]             ang_sat;
   logic signed [ANG_W-1:0] ang_val;
   logic signed [48:0]      ang_diff, ang_sum;
   logic                    ok;
   logic [54:0]             dist_raw;
   logic signed [32:0]      h_sum;
   logic [31:0]             wrap_thr, wrap_mag;
   logic                    c_done;
   logic signed [ROT_W-1:0] c_val, s_val, c_abs, s_abs;
   logic [POS_W-1:0]        step_r;

   assign q_pop       = ctl.pop;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   ddo_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.cordic_start),
      .heading(heading_ff),
      .done   (c_done),
      .cos_out(c_val),
      .sin_out(s_val)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_valid) state_in = ST_ANGLE;
         ST_ANGLE:  if (ph_ff == 2'd3) state_in = ST_DALF;
         ST_DALF:   if (ph_ff == 2'd2) state_in = ST_CHECK;
         ST_CHECK:  state_in = ok ? ST_DIST : ST_OUT;
         ST_DIST:   if (ph_ff == 2'd2) state_in = ST_HSUM;
         ST_HSUM:   state_in = ST_WRAP;
         ST_WRAP:   if (wstep_ff == '0) state_in = ST_CSTART;
         ST_CSTART: state_in = ST_CWAIT;
         ST_CWAIT:  if (c_done) state_in = ST_XMUL;
         ST_XMUL:   if (ph_ff == 2'd2) state_in = ST_XADD;
         ST_XADD:   state_in = ST_YMUL;
         ST_YMUL:   if (ph_ff == 2'd2) state_in = ST_YADD;
         ST_YADD:   state_in = ST_OUT;
         ST_OUT:    if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      ph_in = (state_in != state_ff) ? 2'd0 : ph_ff + 2'd1;
   end

   // control strobes
   always_comb begin
      ctl.pop          = (state_ff == ST_IDLE) && q_valid;
      ctl.cordic_start = (state_ff == ST_CSTART);
      ctl.rsp_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in     = ctl.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // multiplier operands and shared arithmetic
   always_comb begin
      d_mag = (ph_ff == 2'd0) ? (d0_ff[CNT_W-1] ? 32'(-d0_ff) : 32'(d0_ff))
                              : (d1_ff[CNT_W-1] ? 32'(-d1_ff) : 32'(d1_ff));
      mul_b = m_ff;
      if (state_ff == ST_ANGLE) begin
         mul_a = d_mag;
         mul_b = cfg.count_to_radian;
      end else if (ph_ff == 2'd0) begin
         mul_a = {8'b0, mag_ff[23:0]};
      end else begin
         mul_a = {8'b0, mag_ff[47:24]};
      end
      prod_in = mul_a * mul_b;

      // saturated wheel angle from last product; sign of the previous delta
      ang_sat = (|prod_ff[63:47]) ? SAT47 : prod_ff[46:0];
      ang_val = ((ph_ff == 2'd1) ? d0_ff[CNT_W-1] : d1_ff[CNT_W-1]) ?
                -$signed({1'b0, ang_sat}) : $signed({1'b0, ang_sat});
      ang_diff = 49'(a0_ff) - 49'(a1_ff);
      ang_sum  = 49'(a0_ff) + 49'(a1_ff);

      ok       = acc_ff[79:24] < {25'b0, cfg.glitch_limit};
      dist_raw = acc_ff[79:25];

      h_sum = 33'(heading_ff) + (dalf_neg_ff ? -$signed({2'b0, dalf_mag_ff})
                                             : $signed({2'b0, dalf_mag_ff}));

      wrap_thr = TWO_PI_U << wstep_ff;
      wrap_mag = (h_mag_ff >= wrap_thr) ? h_mag_ff - wrap_thr : h_mag_ff;

      c_abs  = c_val[ROT_W-1] ? -c_val : c_val;
      s_abs  = s_val[ROT_W-1] ? -s_val : s_val;
      step_r = acc_ff[77:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         heading_ff   <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_WRAP && wstep_ff == '0) begin
            heading_ff <= h_neg_ff ? -HEAD_W'(wrap_mag) : HEAD_W'(wrap_mag);
         end
         if (state_ff == ST_XADD) begin
            x_ff <= neg_ff ? x_ff - step_r : x_ff + step_r;
         end
         if (state_ff == ST_YADD) begin
            y_ff <= neg_ff ? y_ff - step_r : y_ff + step_r;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      // three-phase multiply: low half, high half, merge
      if (ph_ff == 2'd1) begin
         acc_ff <= {16'b0, prod_ff};
      end else if (ph_ff == 2'd2) begin
         acc_ff <= acc_ff + {prod_ff[55:0], 24'b0};
      end
      unique case (state_ff)
         ST_IDLE: begin
            d0_ff <= q_data.d_left;
            d1_ff <= q_data.d_right;
         end
         ST_ANGLE: begin
            if (ph_ff == 2'd1) a0_ff <= ang_val;
            if (ph_ff == 2'd2) a1_ff <= ang_val;
            if (ph_ff == 2'd3) begin
               mag_ff <= ang_diff[48] ? 48'(-ang_diff) : 48'(ang_diff);
               neg_ff <= ang_diff[48];
               m_ff   <= cfg.rotation_scale;
            end
         end
         ST_CHECK: begin
            ok_ff       <= ok;
            dalf_neg_ff <= neg_ff;
            dalf_mag_ff <= acc_ff[54:24];
            mag_ff      <= ang_sum[48] ? 48'(-ang_sum) : 48'(ang_sum);
            neg_ff      <= ang_sum[48];
            m_ff        <= cfg.wheel_radius;
         end
         ST_HSUM: begin
            dist_neg_ff <= neg_ff;
            dist_mag_ff <= (|dist_raw[54:47]) ? SAT47 : dist_raw[46:0];
            h_neg_ff    <= h_sum[32];
            h_mag_ff    <= h_sum[32] ? 32'(-h_sum) : 32'(h_sum);
            wstep_ff    <= 3'd4;
         end
         ST_WRAP: begin
            h_mag_ff <= wrap_mag;
            wstep_ff <= wstep_ff - 3'd1;
         end
         ST_CWAIT: begin
            mag_ff <= {1'b0, dist_mag_ff};
            m_ff   <= c_abs[31:0];
            neg_ff <= dist_neg_ff ^ c_val[ROT_W-1];
         end
         ST_XADD: begin
            mag_ff <= {1'b0, dist_mag_ff};
            m_ff   <= s_abs[31:0];
            neg_ff <= dist_neg_ff ^ s_val[ROT_W-1];
         end
         ST_OUT: begin
            if (ctl.rsp_load) begin
               rsp_ff.pos_x        <= $signed(x_ff);
               rsp_ff.pos_y        <= $signed(y_ff);
               rsp_ff.heading      <= heading_ff;
               rsp_ff.pose_updated <= ok_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/core/differential_drive_odometry.sv]
// Top level of the differential-drive odometry block: CSR bank, front, queue, back.
// Depends on ddo_pkg, ddo_front, ddo_queue, ddo_back (and ddo_cordic below it).
`timescale 1ns / 1ps
//
//   port group  | dir | beat carries                        | handshake
//   req_*       | in  | left/right counts, clear_history    | req_valid / req_ready
//   rsp_*       | out | pos_x, pos_y, heading, pose_updated | rsp_valid / rsp_ready
//   csr_*       | in  | register index, 32-bit data         | csr_valid / csr_ready
//
// An accepted item runs through the back-end states from pop to result load; the
// iterative CORDIC (one micro-rotation a cycle) and the shared multiplier set its
// length. A step rejected as a glitch goes from the check straight to result load.
// The front accepts beats into a 2-entry delta queue until it is full, while the back
// works and while a result waits in the output register. Reset is synchronous and
// clears the stored counts, pose and all control state; csr_ready is always high.

module differential_drive_odometry import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ddo_req_type          req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ddo_rsp_type          rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   ddo_cfg_type   cfg_ff, cfg_in;
   logic          q_full, q_push, q_pop, q_valid;
   ddo_delta_type q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COUNT_TO_RADIAN: cfg_in.count_to_radian = csr_data;
            CSR_ROTATION_SCALE:  cfg_in.rotation_scale  = csr_data;
            CSR_WHEEL_RADIUS:    cfg_in.wheel_radius    = csr_data;
            CSR_GLITCH_LIMIT:    cfg_in.glitch_limit    = csr_data[LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_to_radian <= RST_COUNT_TO_RADIAN;
         cfg_ff.rotation_scale  <= RST_ROTATION_SCALE;
         cfg_ff.wheel_radius    <= RST_WHEEL_RADIUS;
         cfg_ff.glitch_limit    <= RST_GLITCH_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ddo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .q_full     (q_full),
      .push       (q_push),
      .push_data  (q_wdata)
   );

   ddo_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_rdata),
      .not_empty(q_valid)
   );

   ddo_back #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_data     (q_rdata),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // heading stays wrapped inside (-2pi, 2pi)
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.heading < TWO_PI) && (rsp_payload.heading > -TWO_PI))
      else $error("heading out of wrap range");

   // a zero glitch limit rejects every step
   a_zero_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cfg_ff.glitch_limit == '0) |-> !rsp_payload.pose_updated)
      else $error("step accepted with zero glitch limit");

   // the back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty delta queue");

endmodule

[tb/tb_differential_drive_odometry.sv]
// Self-checking testbench for differential_drive_odometry: table-driven directed beats,
// then random count sequences, all checked against an in-bench pose predictor.
// Depends on ddo_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_differential_drive_odometry;
   import ddo_pkg::*;

   localparam int NUM_RANDOM = 1700;
   localparam int SETTLE     = 80;
   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 3'd7;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_data;
   ddo_req_type req_payload;
   ddo_rsp_type rsp_payload;

   differential_drive_odometry dut (.*);

   // predictor state
   logic [31:0] p_c2r, p_rot, p_rad;
   logic [30:0] p_lim;
   logic [31:0] p_last [2];
   logic [47:0] p_x, p_y;
   longint      p_head;

   ddo_rsp_type pose_fifo [$];
   int          errors = 0;
   int          n_rsp = 0;
   int          n_glitch = 0;
   bit          hold_rsp = 0;

   // directed table: expected pose typed only where obvious
   typedef struct {
      ddo_req_type req;
      bit          has_exp;
      ddo_rsp_type exp;
   } dir_row_type;

   function automatic longint floor_shr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-(v + 1)) >>> s) - 1;
   endfunction

   function automatic longint sat_mag(longint m, bit neg);
      if (m > longint'(SAT47)) m = longint'(SAT47);
      return neg ? -m : m;
   endfunction

   // exact floor(|a| * m >> sh) with sign, 128-bit intermediate
   function automatic longint scaled(longint a, logic [63:0] m, int sh, bit neg_m);
      logic [127:0] p;
      longint       mag;
      mag = (a < 0) ? -a : a;
      p = (128'(mag) * 128'(m)) >> sh;
      return ((a < 0) != neg_m) ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint angle_of(logic [31:0] cur, int w);
      logic [31:0] du;
      longint      d;
      du = (p_last[w] == 0) ? 32'd0 : cur - p_last[w];
      p_last[w] = cur;
      d = longint'($signed(du));
      return sat_mag(((d < 0) ? -d : d) * longint'(p_c2r), d < 0);
   endfunction

   task automatic rotate(input longint h, output longint c, output longint s);
      longint x, y, z, nx;
      bit     flip;
      flip = 0;
      if (h > PI) h -= TWO_PI;
      else if (h < -longint'(PI)) h += TWO_PI;
      if (h > HALF_PI) begin
         h -= PI; flip = 1;
      end else if (h < -longint'(HALF_PI)) begin
         h += PI; flip = 1;
      end
      x = CORDIC_GAIN; y = 0; z = h * 64;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         if (z >= 0) begin
            nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= atan_q30(i[4:0]);
         end else begin
            nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += atan_q30(i[4:0]);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic void predictor_reset();
      p_c2r = RST_COUNT_TO_RADIAN; p_rot = RST_ROTATION_SCALE;
      p_rad = RST_WHEEL_RADIUS; p_lim = RST_GLITCH_LIMIT;
      p_last[0] = 0; p_last[1] = 0; p_x = 0; p_y = 0; p_head = 0;
   endfunction

   task automatic predict_pose(input ddo_req_type r, output ddo_rsp_type o);
      longint a0, a1, dalf, travel, h, c, s, lim;
      bit     ok;
      lim = p_lim;
      if (r.clear_history) begin
         p_last[0] = 0; p_last[1] = 0;
      end
      a0 = angle_of(r.left_count, 0);
      a1 = angle_of(r.right_count, 1);
      dalf = scaled(a0 - a1, p_rot, 24, 0);
      ok = (dalf < lim) && (dalf > -lim);
      if (ok) begin
         travel = scaled(a0 + a1, p_rad, 25, 0);
         travel = sat_mag((travel < 0) ? -travel : travel, travel < 0);
         h = p_head + dalf;
         if (h >= TWO_PI) h = h % TWO_PI;
         else if (h <= -longint'(TWO_PI)) h = -((-h) % TWO_PI);
         p_head = longint'($signed(32'(h)));
         rotate(h, c, s);
         p_x = p_x + 48'(scaled(travel, (c < 0) ? -c : c, 30, c < 0));
         p_y = p_y + 48'(scaled(travel, (s < 0) ? -s : s, 30, s < 0));
      end
      o.pos_x = p_x; o.pos_y = p_y;
      o.heading = p_head[HEAD_W-1:0]; o.pose_updated = ok;
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
   end

   // one register write while the block is idle, then csr_valid low again before return
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COUNT_TO_RADIAN: p_c2r = val;
         CSR_ROTATION_SCALE:  p_rot = val;
         CSR_WHEEL_RADIUS:    p_rad = val;
         CSR_GLITCH_LIMIT:    p_lim = val[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pose_fifo.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // send one beat; expected pose either typed or predicted
   task automatic send_beat(input ddo_req_type r, input bit has_exp, input ddo_rsp_type e);
      ddo_rsp_type p;
      int          gap;
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : 0;
      // valid drops only when an idle gap comes before this beat
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1; req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predict_pose(r, p);
      if (has_exp && p != e)
         $display("%0t directed row disagrees with predictor: %h vs %h", $time, e, p);
      pose_fifo.push_back(has_exp ? e : p);
      @(negedge clock);
   endtask

   function automatic ddo_req_type mk(int l, int r, bit c);
      ddo_req_type q;
      q.left_count = l; q.right_count = r; q.clear_history = c;
      return q;
   endfunction

   // result side: random stall per beat, with one long hold-off
   initial begin
      int gap;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         gap = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 6) : 0;
         if (gap != 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // compare each accepted pose with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pose_fifo.size() == 0) begin
            $display("%0t unexpected pose beat: actual %h", $time, rsp_payload);
            errors++;
         end else begin
            ddo_rsp_type e;
            e = pose_fifo.pop_front();
            n_rsp++;
            if (!e.pose_updated) n_glitch++;
            if (e.pos_x !== rsp_payload.pos_x || e.pos_y !== rsp_payload.pos_y ||
                e.heading !== rsp_payload.heading ||
                e.pose_updated !== rsp_payload.pose_updated) begin
               $display("%0t pose mismatch: expected %h actual %h", $time, e, rsp_payload);
               errors++;
            end
         end
      end
   end

   initial begin
      dir_row_type  rows [$];
      dir_row_type  row;
      ddo_rsp_type  zero_pose;
      int           l, r, base_l, base_r;
      zero_pose = '0;
      reset = 1; req_valid = 0; req_payload = '0;
      csr_valid = 0; csr_index = '0; csr_data = '0;
      predictor_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: first beat has no history, so the pose stays at zero
      row.has_exp = 1; row.exp = zero_pose; row.exp.pose_updated = 1;
      row.req = mk(32'h7fffffff, 32'h80000000, 0); rows.push_back(row);
      row.has_exp = 0;
      row.req = mk(100, 100, 0);                   rows.push_back(row);
      row.req = mk(300, 200, 0);                   rows.push_back(row);
      row.req = mk(0, 0, 0);                       rows.push_back(row);
      row.req = mk(50, -50, 0);                    rows.push_back(row);
      row.req = mk(-1, -1, 1);                     rows.push_back(row);
      row.req = mk(32'h80000000, 32'h7fffffff, 0); rows.push_back(row);
      row.req = mk(32'h7fffffff, 32'h80000000, 0); rows.push_back(row);
      row.req = mk(1, 1, 1);                       rows.push_back(row);
      row.req = mk(-20000, 20000, 0);              rows.push_back(row);
      row.req = mk(-40000, 40000, 0);              rows.push_back(row);
      row.req = mk(40000, 40000, 0);               rows.push_back(row);
      foreach (rows[i]) send_beat(rows[i].req, rows[i].has_exp, rows[i].exp);
      drain();

      // zero limit: every step is a glitch, pose unchanged
      csr_write(CSR_GLITCH_LIMIT, 32'h0);
      send_beat(mk(5, 9, 0), 0, zero_pose);
      send_beat(mk(5, 9, 0), 0, zero_pose);
      drain();
      csr_write(CSR_GLITCH_LIMIT, 32'hffffffff);
      csr_write(CSR_COUNT_TO_RADIAN, 32'hffffffff);
      csr_write(CSR_ROTATION_SCALE, 32'hffffffff);
      csr_write(CSR_WHEEL_RADIUS, 32'hffffffff);
      csr_write(CSR_NO_REG, 32'h12345678);
      send_beat(mk(32'h80000000, 32'h7fffffff, 0), 0, zero_pose);
      send_beat(mk(32'h7fffffff, 32'h80000000, 0), 0, zero_pose);
      send_beat(mk(3, 5, 0), 0, zero_pose);
      drain();
      csr_write(CSR_COUNT_TO_RADIAN, 0);
      csr_write(CSR_ROTATION_SCALE, 0);
      csr_write(CSR_WHEEL_RADIUS, 0);
      send_beat(mk(1000, 7, 0), 0, zero_pose);
      drain();

      // random phases over several register settings
      base_l = $urandom; base_r = $urandom;
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         csr_write(CSR_COUNT_TO_RADIAN, (ph == 3) ? $urandom : $urandom_range(1000, 300000));
         csr_write(CSR_ROTATION_SCALE, (ph == 3) ? $urandom : $urandom_range(1 << 22, 1 << 26));
         csr_write(CSR_WHEEL_RADIUS, (ph == 3) ? $urandom : $urandom_range(1 << 18, 1 << 25));
         csr_write(CSR_GLITCH_LIMIT, (ph == 0) ? RST_GLITCH_LIMIT : $urandom);
         for (int n = 0; n < NUM_RANDOM / 4; n++) begin
            if (ph == 1 && n == 100) hold_rsp = 1;
            if (n == 200) drain();
            if ($urandom_range(0, 9) == 0) begin
               l = $urandom; r = $urandom;
            end else begin
               base_l += $signed($urandom_range(0, 4000)) - 2000;
               base_r += $signed($urandom_range(0, 4000)) - 2000;
               l = base_l; r = base_r;
            end
            send_beat(mk(l, r, $urandom_range(0, 19) == 0), 0, zero_pose);
         end
      end

      drain();
      $display("Covered %0d pose beats, %0d of them rejected as glitches,", n_rsp, n_glitch);
      $display("across default, extreme, zero and random register settings.");
      if (errors == 0 && pose_fifo.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/core/ddo_pkg.sv
rtl/core/ddo_front.sv
rtl/core/ddo_queue.sv
rtl/core/ddo_cordic.sv
rtl/core/ddo_back.sv
rtl/core/differential_drive_odometry.sv
tb/tb_differential_drive_odometry.sv
